// ===== src/mahd_pkg.sv =====
package mahd_pkg;

    localparam int WINDOW_LEN = 5;
    localparam int SAMPLE_W   = 12;
    localparam int POS_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int STEP_W     = (SUM_W > 1) ? $clog2(SUM_W) : 1;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SAMPLE_W-1:0] ON_THRESHOLD_RST  = SAMPLE_W'(1700);
    localparam logic [SAMPLE_W-1:0] OFF_THRESHOLD_RST = SAMPLE_W'(1900);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_THRESHOLD  = 1'b0,
        CFG_OFF_THRESHOLD = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

endpackage

// ===== src/mahd_div.sv =====
module mahd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mahd_pkg::SUM_W-1:0]    i_dividend,
    input  logic [mahd_pkg::CNT_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [mahd_pkg::SUM_W-1:0]    o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [mahd_pkg::STEP_W-1:0]   r_step;
    logic [mahd_pkg::SUM_W-1:0]    r_dvd;
    logic [mahd_pkg::SUM_W-1:0]    r_quo;
    logic [mahd_pkg::CNT_W-1:0]    r_rem;
    logic [mahd_pkg::CNT_W-1:0]    r_divisor;

    logic [mahd_pkg::CNT_W:0]      w_trial;
    logic                          w_fits;
    logic [mahd_pkg::CNT_W-1:0]    n_rem;

    // Restoring division, one quotient bit per cycle, dividend taken MSB first.
    // The remainder stays below the divisor, so it never needs more than CNT_W bits.
    always_comb begin
        w_trial = {r_rem, r_dvd[mahd_pkg::SUM_W-1]};
        w_fits  = w_trial >= {1'b0, r_divisor};
        n_rem   = w_fits ? mahd_pkg::CNT_W'(w_trial - {1'b0, r_divisor})
                         : w_trial[mahd_pkg::CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= mahd_pkg::STEP_W'(mahd_pkg::SUM_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd     <= i_dividend;
            r_divisor <= i_divisor;
            r_rem     <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[mahd_pkg::SUM_W-2:0], 1'b0};
            r_quo <= {r_quo[mahd_pkg::SUM_W-2:0], w_fits};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_divisor))
        else $error("divider remainder reached the divisor");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_divisor != '0))
        else $error("divider running with a zero divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding step");

endmodule

// ===== src/moving_average_hysteresis_detector.sv =====
// Moving-average light detector. Each sample transfer updates a five-entry window and its
// running sum in the accept cycle; the sum is then divided by the number of samples held
// (up to five) in a bit-serial restoring divider that retires one quotient bit per cycle
// over the fifteen bits of the sum. The truncated average drives an on/off detector with
// separate on and off thresholds, and one result carrying the average and the detector
// state is presented through an output register. A sample is taken only while idle, so
// the next one waits until the divider is through with this one; a result not yet taken
// holds off the next sample only once its successor has finished dividing. The user must
// write thresholds through the configuration port while idle; the block does not enforce it.
module moving_average_hysteresis_detector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [mahd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mahd_pkg::SAMPLE_W-1:0]      i_cfg_data,
    input  logic                               i_sample_valid,
    output logic                               o_sample_ready,
    input  logic [mahd_pkg::SAMPLE_W-1:0]      i_sample,
    output logic                               o_result_valid,
    input  logic                               i_result_ready,
    output logic [mahd_pkg::SAMPLE_W-1:0]      o_average,
    output logic                               o_output_on
);

    mahd_pkg::t_state                  r_state;
    mahd_pkg::t_state                  n_state;

    logic [mahd_pkg::SAMPLE_W-1:0]     r_on_thr;
    logic [mahd_pkg::SAMPLE_W-1:0]     r_off_thr;

    logic [mahd_pkg::SAMPLE_W-1:0]     r_win [mahd_pkg::WINDOW_LEN];
    logic [mahd_pkg::SUM_W-1:0]        r_sum;
    logic [mahd_pkg::SUM_W-1:0]        n_sum;
    logic [mahd_pkg::POS_W-1:0]        r_pos;
    logic [mahd_pkg::CNT_W-1:0]        r_fill;
    logic [mahd_pkg::CNT_W-1:0]        n_fill;
    logic                              w_full;
    logic [mahd_pkg::SAMPLE_W-1:0]     w_oldest;

    logic                              r_out_valid;
    logic [mahd_pkg::SAMPLE_W-1:0]     r_avg;
    logic                              r_det_on;
    logic                              n_det_on;

    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_load;
    logic                              w_div_done;
    logic [mahd_pkg::SUM_W-1:0]        w_quo;
    logic [mahd_pkg::SAMPLE_W-1:0]     w_avg;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_thr  <= mahd_pkg::ON_THRESHOLD_RST;
            r_off_thr <= mahd_pkg::OFF_THRESHOLD_RST;
        end else if (i_cfg_wr_en) begin
            unique case (mahd_pkg::t_cfg_reg'(i_cfg_index))
                mahd_pkg::CFG_ON_THRESHOLD:  r_on_thr  <= i_cfg_data;
                mahd_pkg::CFG_OFF_THRESHOLD: r_off_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Window update happens in the transfer cycle; the oldest entry is only removed once
    // the ring is full, so an entry is never read before it has been written.
    always_comb begin
        w_full   = r_fill == mahd_pkg::CNT_W'(mahd_pkg::WINDOW_LEN);
        w_oldest = w_full ? r_win[r_pos] : '0;
        n_sum    = r_sum - mahd_pkg::SUM_W'(w_oldest) + mahd_pkg::SUM_W'(i_sample);
        n_fill   = w_full ? r_fill : r_fill + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_fill <= '0;
        end else if (w_accept) begin
            r_sum  <= n_sum;
            r_fill <= n_fill;
            if (r_pos == mahd_pkg::POS_W'(mahd_pkg::WINDOW_LEN - 1)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win[r_pos] <= i_sample;
        end
    end

    mahd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (n_sum),
        .i_divisor  (n_fill),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // The mean of 12-bit samples always fits in 12 bits.
    assign w_avg = w_quo[mahd_pkg::SAMPLE_W-1:0];

    always_comb begin
        n_det_on = r_det_on;
        if (!r_det_on) begin
            if (w_avg < r_on_thr) begin
                n_det_on = 1'b1;
            end
        end else begin
            if (w_avg > r_off_thr) begin
                n_det_on = 1'b0;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mahd_pkg::S_IDLE: begin
                if (i_sample_valid) begin
                    n_state = mahd_pkg::S_DIV;
                end
            end
            mahd_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = w_out_free ? mahd_pkg::S_IDLE : mahd_pkg::S_HOLD;
                end
            end
            mahd_pkg::S_HOLD: begin
                if (w_out_free) begin
                    n_state = mahd_pkg::S_IDLE;
                end
            end
            default: n_state = mahd_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        w_out_free     = !r_out_valid || i_result_ready;
        o_sample_ready = 1'b0;
        w_load         = 1'b0;
        unique case (r_state)
            mahd_pkg::S_IDLE: o_sample_ready = 1'b1;
            mahd_pkg::S_DIV:  w_load = w_div_done && w_out_free;
            mahd_pkg::S_HOLD: w_load = w_out_free;
            default: ;
        endcase
        w_accept = o_sample_ready && i_sample_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mahd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_det_on    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_det_on    <= n_det_on;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_avg <= w_avg;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_average      = r_avg;
    assign o_output_on    = r_det_on;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= mahd_pkg::CNT_W'(mahd_pkg::WINDOW_LEN))
        else $error("fill count passed the window length");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == mahd_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == mahd_pkg::S_DIV && r_fill != '0))
        else $error("sample transfer did not start a division");

endmodule
